/* hdl/dmpp_pkg.sv */
// ----------------------------------------------------------------------------
// dmpp_pkg
// Shared widths, register and command codes, and the lane/merge handshake
// types for the dual-wheel position controller.
// ----------------------------------------------------------------------------
package dmpp_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int GAIN_W     = 24;
  localparam int OFS_W      = 6;
  localparam int FWD_W      = 16;
  localparam int TURN_W     = 15;
  localparam int BAND_W     = 8;
  localparam int SUM_W      = 32;
  localparam int DRIVE_W    = 9;
  localparam int MAG_W      = 7;
  localparam int CMD_W      = 3;
  localparam int HEAD_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DRIVE_MIN = 50;
  localparam int DRIVE_MAX = 100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_CNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_CNT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd7;

  // reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 24'd66;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 24'd6554;
  localparam logic [FWD_W-1:0]  FWD_CNT_RST  = 16'd1800;
  localparam logic [TURN_W-1:0] TURN_CNT_RST = 15'd750;
  localparam logic [BAND_W-1:0] SETTLE_RST   = 8'd10;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABOUT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;

  // sequencer strobes into each lane
  typedef struct packed {
    logic err_en;
    logic mul_en;
    logic run;
  } dmpp_step_t;

  // what a lane found for the current tick
  typedef struct packed {
    logic                      act;
    logic signed [DRIVE_W-1:0] drive;
  } dmpp_lane_res_t;

endpackage

/* hdl/dmpp_lane.sv */
// ----------------------------------------------------------------------------
// dmpp_lane
// One wheel: error, settle check, saturating integrator, three gain products
// and the clamp/truncate/offset stage for the motor drive.
// ----------------------------------------------------------------------------
module dmpp_lane #(
  parameter int COUNT_BITS = dmpp_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = dmpp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dmpp_pkg::dmpp_step_t               step_i,
  input  logic signed [COUNT_BITS-1:0]       goal_i,
  input  logic signed [COUNT_BITS:0]         pos_i,
  input  logic [dmpp_pkg::GAIN_W-1:0]        gain_p_i,
  input  logic [dmpp_pkg::GAIN_W-1:0]        gain_i_i,
  input  logic [dmpp_pkg::GAIN_W-1:0]        gain_d_i,
  input  logic [dmpp_pkg::BAND_W-1:0]        band_i,
  input  logic [dmpp_pkg::OFS_W-1:0]         offset_i,
  output dmpp_pkg::dmpp_lane_res_t           res_o
);

  localparam int EW    = COUNT_BITS + 1;
  localparam int DW    = COUNT_BITS + 2;
  localparam int SW    = dmpp_pkg::SUM_W;
  localparam int GW    = dmpp_pkg::GAIN_W + 1;
  localparam int MW    = (DW > SW) ? DW : SW;
  localparam int ACC_W = GW + MW + 2;
  localparam int PP_W  = GW + EW;
  localparam int PI_W  = GW + SW;
  localparam int PD_W  = GW + DW;

  localparam logic [ACC_W-1:0] LO_LIM = ACC_W'(dmpp_pkg::DRIVE_MIN) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HI_LIM = ACC_W'(dmpp_pkg::DRIVE_MAX) << FRAC_BITS;
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  // integrator and derivative memory
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [EW-1:0] prev_q, prev_d;
  logic                 act_q, act_d;

  // per-tick working registers
  logic signed [EW-1:0]   e_q;
  logic signed [DW-1:0]   dlt_q;
  logic signed [PP_W-1:0] pp_q;
  logic signed [PI_W-1:0] pi_q;
  logic signed [PD_W-1:0] pd_q;

  logic signed [EW-1:0]   e_c;
  logic [EW-1:0]          e_mag;
  logic                   settled;
  logic signed [SW+1:0]   sum_x;
  logic signed [SW-1:0]   sum_sat;

  logic signed [ACC_W-1:0] acc;
  logic                    acc_pos;
  logic [ACC_W-1:0]        acc_mag;
  logic [dmpp_pkg::MAG_W-1:0] cl_mag;
  logic signed [dmpp_pkg::DRIVE_W-1:0] mag_s, drv;

  always_comb begin
    e_c     = EW'(goal_i) - pos_i;
    e_mag   = e_c[EW-1] ? EW'(-e_c) : EW'(e_c);
    settled = e_mag <= {{(EW-dmpp_pkg::BAND_W){1'b0}}, band_i};
    sum_x   = (SW+2)'(sum_q) + (SW+2)'(e_c);
    if (sum_x[SW+1:SW-1] == 3'b000 || sum_x[SW+1:SW-1] == 3'b111) begin
      sum_sat = sum_x[SW-1:0];
    end else if (sum_x[SW+1]) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = SUM_MAX;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    prev_d = prev_q;
    act_d  = act_q;
    if (step_i.err_en) begin
      act_d = 1'b0;
      if (step_i.run) begin
        if (settled) begin
          sum_d  = '0;
          prev_d = '0;
        end else begin
          sum_d  = sum_sat;
          prev_d = e_c;
          act_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
      act_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      prev_q <= prev_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.err_en) begin
      e_q   <= e_c;
      dlt_q <= DW'(e_c) - DW'(prev_q);
    end
    if (step_i.mul_en) begin
      pp_q <= signed'({1'b0, gain_p_i}) * e_q;
      pi_q <= signed'({1'b0, gain_i_i}) * sum_q;
      pd_q <= signed'({1'b0, gain_d_i}) * dlt_q;
    end
  end

  // clamp to 50..100 in magnitude, truncate toward zero, add offset
  always_comb begin
    acc     = ACC_W'(pp_q) + ACC_W'(pi_q) + ACC_W'(pd_q);
    acc_pos = !acc[ACC_W-1] && (acc != '0);
    acc_mag = acc_pos ? ACC_W'(acc) : ACC_W'(-acc);
    if (acc_mag >= HI_LIM) begin
      cl_mag = dmpp_pkg::MAG_W'(dmpp_pkg::DRIVE_MAX);
    end else if (acc_mag < LO_LIM) begin
      cl_mag = dmpp_pkg::MAG_W'(dmpp_pkg::DRIVE_MIN);
    end else begin
      cl_mag = acc_mag[FRAC_BITS +: dmpp_pkg::MAG_W];
    end
    mag_s = signed'({{(dmpp_pkg::DRIVE_W-dmpp_pkg::MAG_W){1'b0}}, cl_mag});
    drv   = (acc_pos ? mag_s : -mag_s)
          + signed'({{(dmpp_pkg::DRIVE_W-dmpp_pkg::OFS_W){1'b0}}, offset_i});
  end

  assign res_o.act   = act_q;
  assign res_o.drive = act_q ? drv : '0;

endmodule

/* hdl/dmpp_merge.sv */
// ----------------------------------------------------------------------------
// dmpp_merge
// Combines both lanes: decides when the move has settled, keeps the finish
// flag and holds the result transaction in the output register.
// ----------------------------------------------------------------------------
module dmpp_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dmpp_pkg::dmpp_lane_res_t            left_i,
  input  dmpp_pkg::dmpp_lane_res_t            right_i,
  input  logic                                moving_i,
  input  logic                                mul_en_i,
  input  logic                                fin_en_i,
  input  logic [dmpp_pkg::HEAD_W-1:0]         heading_i,
  output logic                                done_o,
  output logic                                out_free_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dmpp_pkg::DRIVE_W-1:0] left_drive_o,
  output logic signed [dmpp_pkg::DRIVE_W-1:0] right_drive_o,
  output logic                                busy_res_o,
  output logic                                clear_counts_o,
  output logic [dmpp_pkg::HEAD_W-1:0]         heading_now_o
);

  logic clear_q;
  logic out_valid_q;
  logic wr_en;

  assign done_o     = moving_i && !left_i.act && !right_i.act;
  assign out_free_o = !out_valid_q || out_ready_i;
  assign wr_en      = fin_en_i && out_free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_en_i) begin
        clear_q <= done_o;
      end
      if (wr_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      left_drive_o   <= left_i.drive;
      right_drive_o  <= right_i.drive;
      busy_res_o     <= moving_i;
      clear_counts_o <= clear_q;
      heading_now_o  <= heading_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/dual_motor_position_pid.sv */
// ----------------------------------------------------------------------------
// dual_motor_position_pid
// Two-wheel position controller: move commands, per-wheel clamped PID lanes,
// settle detection and encoder-reset request.
// ----------------------------------------------------------------------------
// Each accepted tick runs through the ERR, MUL and FIN phases: ERR forms both
// wheel errors and updates the integrators, MUL does the three gain multiplies
// in each wheel lane, and FIN sums, clamps and registers the drive. The next
// tick is accepted in the cycle its predecessor's result is registered, not
// while one is in flight, as this error-multiply-clamp sequence closes through
// the integrator and goal state. A finished result
// waiting on out_ready_i only stalls input once the next result is ready to
// be written. Configuration writes are taken in any cycle (cfg_ready_o is
// always high) and must only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_motor_position_pid #(
  parameter int COUNT_BITS = dmpp_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = dmpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dmpp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dmpp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dmpp_pkg::CMD_W-1:0]            cmd_i,
  input  logic signed [COUNT_BITS-1:0]          left_count_i,
  input  logic signed [COUNT_BITS-1:0]          right_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dmpp_pkg::DRIVE_W-1:0]   left_drive_o,
  output logic signed [dmpp_pkg::DRIVE_W-1:0]   right_drive_o,
  output logic                                  busy_res_o,
  output logic                                  clear_counts_o,
  output logic [dmpp_pkg::HEAD_W-1:0]           heading_now_o
);

  localparam int EW  = COUNT_BITS + 1;
  localparam int TW  = COUNT_BITS + 2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ERR  = 2'd1;
  localparam logic [1:0] PH_MUL  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  // configuration
  logic [dmpp_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [dmpp_pkg::OFS_W-1:0]  left_ofs_q, right_ofs_q;
  logic [dmpp_pkg::FWD_W-1:0]  fwd_cnt_q;
  logic [dmpp_pkg::TURN_W-1:0] turn_cnt_q;
  logic [dmpp_pkg::BAND_W-1:0] settle_q;

  // move state
  logic [1:0]                  phase_q, phase_d;
  logic signed [COUNT_BITS-1:0] goal_l_q, goal_l_d, goal_r_q, goal_r_d;
  logic                        moving_q, moving_d;
  logic [dmpp_pkg::HEAD_W-1:0] heading_q, heading_d;
  logic signed [EW-1:0]        pos_l_q, pos_r_q;

  logic accept;
  logic done, out_free;
  logic signed [TW-1:0] fwd_v, turn_v, gl, gr;

  dmpp_pkg::dmpp_step_t     step;
  dmpp_pkg::dmpp_lane_res_t res_l, res_r;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= dmpp_pkg::GAIN_P_RST;
      gain_i_q    <= dmpp_pkg::GAIN_I_RST;
      gain_d_q    <= dmpp_pkg::GAIN_D_RST;
      left_ofs_q  <= '0;
      right_ofs_q <= '0;
      fwd_cnt_q   <= dmpp_pkg::FWD_CNT_RST;
      turn_cnt_q  <= dmpp_pkg::TURN_CNT_RST;
      settle_q    <= dmpp_pkg::SETTLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmpp_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data_i;
        dmpp_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data_i;
        dmpp_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data_i;
        dmpp_pkg::REG_LEFT_OFS:  left_ofs_q  <= cfg_data_i[dmpp_pkg::OFS_W-1:0];
        dmpp_pkg::REG_RIGHT_OFS: right_ofs_q <= cfg_data_i[dmpp_pkg::OFS_W-1:0];
        dmpp_pkg::REG_FWD_CNT:   fwd_cnt_q   <= cfg_data_i[dmpp_pkg::FWD_W-1:0];
        dmpp_pkg::REG_TURN_CNT:  turn_cnt_q  <= cfg_data_i[dmpp_pkg::TURN_W-1:0];
        dmpp_pkg::REG_SETTLE:    settle_q    <= cfg_data_i[dmpp_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (phase_q == PH_IDLE) || ((phase_q == PH_FIN) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (accept) phase_d = PH_ERR;
      PH_ERR:  phase_d = PH_MUL;
      PH_MUL:  phase_d = PH_FIN;
      PH_FIN:  if (out_free) phase_d = accept ? PH_ERR : PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // goal and heading update: a command starts a move only when no move is in progress
  always_comb begin
    goal_l_d  = goal_l_q;
    goal_r_d  = goal_r_q;
    moving_d  = moving_q;
    heading_d = heading_q;
    fwd_v     = signed'(TW'(fwd_cnt_q));
    turn_v    = signed'(TW'(turn_cnt_q));
    gl        = '0;
    gr        = '0;
    if (phase_q == PH_MUL && done) begin
      goal_l_d = '0;
      goal_r_d = '0;
      moving_d = 1'b0;
    end
    if (accept && !moving_q) begin
      case (cmd_i)
        dmpp_pkg::CMD_FWD: begin
          gl = fwd_v;
          gr = fwd_v;
          moving_d = 1'b1;
        end
        dmpp_pkg::CMD_LEFT: begin
          gl = -turn_v;
          gr = turn_v;
          heading_d = heading_q - 2'd1;
          moving_d = 1'b1;
        end
        dmpp_pkg::CMD_RIGHT: begin
          gl = turn_v;
          gr = -turn_v;
          heading_d = heading_q + 2'd1;
          moving_d = 1'b1;
        end
        dmpp_pkg::CMD_ABOUT: begin
          gl = turn_v <<< 1;
          gr = -(turn_v <<< 1);
          heading_d = heading_q + 2'd2;
          moving_d = 1'b1;
        end
        dmpp_pkg::CMD_STOP: begin
          moving_d = 1'b1;
        end
        default: ;
      endcase
      if (moving_d) begin
        goal_l_d = gl[COUNT_BITS-1:0];
        goal_r_d = gr[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      goal_l_q  <= '0;
      goal_r_q  <= '0;
      moving_q  <= 1'b0;
      heading_q <= '0;
    end else begin
      phase_q   <= phase_d;
      goal_l_q  <= goal_l_d;
      goal_r_q  <= goal_r_d;
      moving_q  <= moving_d;
      heading_q <= heading_d;
    end
  end

  // left encoder counts backward
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_l_q <= -EW'(left_count_i);
      pos_r_q <= EW'(right_count_i);
    end
  end

  assign step.err_en = (phase_q == PH_ERR);
  assign step.mul_en = (phase_q == PH_MUL);
  assign step.run    = moving_q;

  dmpp_lane #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .goal_i   (goal_l_q),
    .pos_i    (pos_l_q),
    .gain_p_i (gain_p_q),
    .gain_i_i (gain_i_q),
    .gain_d_i (gain_d_q),
    .band_i   (settle_q),
    .offset_i (left_ofs_q),
    .res_o    (res_l)
  );

  dmpp_lane #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .goal_i   (goal_r_q),
    .pos_i    (pos_r_q),
    .gain_p_i (gain_p_q),
    .gain_i_i (gain_i_q),
    .gain_d_i (gain_d_q),
    .band_i   (settle_q),
    .offset_i (right_ofs_q),
    .res_o    (res_r)
  );

  dmpp_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .left_i         (res_l),
    .right_i        (res_r),
    .moving_i       (moving_q),
    .mul_en_i       (step.mul_en),
    .fin_en_i       (phase_q == PH_FIN),
    .heading_i      (heading_q),
    .done_o         (done),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_drive_o   (left_drive_o),
    .right_drive_o  (right_drive_o),
    .busy_res_o     (busy_res_o),
    .clear_counts_o (clear_counts_o),
    .heading_now_o  (heading_now_o)
  );

  a_clear_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_counts_o |-> !busy_res_o)
    else $error("finished move reported as still busy");

  a_idle_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("nonzero drive on an idle or finishing tick");

  a_move_ends_at_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> $past(phase_q) == PH_MUL)
    else $error("move ended outside the settle check");

  a_err_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERR |=> phase_q == PH_MUL)
    else $error("sequencer skipped the multiply step");

  a_no_accept_midtick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERR || phase_q == PH_MUL) |-> !in_ready_o)
    else $error("input taken while a tick is in flight");

endmodule
